>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the fba_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Types, widths and codes shared by the block allocator modules.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int RING_DEPTH = MAX_BLOCKS + 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = 9;
  localparam int UNITS_W    = 9;
  localparam int ADDR_W     = 24;
  localparam int UNIT_SHIFT = 4;
  // Quotient bits; a larger quotient is always past the pool end.
  localparam int QUO_W      = $clog2(MAX_BLOCKS) + 1;
  localparam int DIVD_W     = ADDR_W - UNIT_SHIFT;
  localparam int HI_W       = DIVD_W - QUO_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int PROD_W     = IDX_W + UNITS_W;

  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam int REG_IDX_W  = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_UNITS = REG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic              init;
    logic [CNT_W-1:0]  init_count;
    logic [CNT_W-1:0]  block_count;
    logic              take_adv;
    logic              ret_wr;
    logic [IDX_W-1:0]  wr_data;
  } ring_ctrl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [IDX_W-1:0]  rd_blk;
  } ring_stat_t;

  typedef struct packed {
    logic               start;
    logic [UNITS_W-1:0] rem_init;
    logic [QUO_W-1:0]   dividend;
    logic [UNITS_W-1:0] divisor;
  } div_req_t;

endpackage

>>> sv/fba_if.sv
// ----------------------------------------------------------------------------
// fba_if
// Request and response channels of the block allocator.
// ----------------------------------------------------------------------------
interface fba_req_if import fba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output operation, output address, input ready);
  modport sink   (input valid, input operation, input address, output ready);
endinterface

interface fba_rsp_if import fba_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ADDR_W-1:0] block_address;
  logic [IDX_W-1:0]  block_index;

  modport source (output valid, output status, output block_address, output block_index,
                  input ready);
  modport sink   (input valid, input status, input block_address, input block_index,
                  output ready);
endinterface

>>> sv/fba_div.sv
// ----------------------------------------------------------------------------
// fba_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fba_div import fba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic               busy;
  logic [STEP_W-1:0]  count;
  logic [UNITS_W-1:0] rem;
  logic [QUO_W-1:0]   shreg;
  logic [UNITS_W-1:0] dvs;

  logic [UNITS_W:0]   trial;
  logic [UNITS_W+1:0] diff;
  logic               take;
  logic [UNITS_W-1:0] rem_next;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial    = {rem, shreg[QUO_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs};
  assign take     = ~diff[UNITS_W+1];
  assign rem_next = take ? diff[UNITS_W-1:0] : trial[UNITS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + STEP_W'(1);
        if (count == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.rem_init;
      shreg <= req.dividend;
      dvs   <= req.divisor;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[QUO_W-2:0], take};
    end
  end

  assign quotient = shreg;

endmodule

>>> sv/fba_ring.sv
// ----------------------------------------------------------------------------
// fba_ring
// Free-index ring: slot memory, take and return pointers, fill count.
// ----------------------------------------------------------------------------
module fba_ring import fba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ring_ctrl_t ctrl,
  output ring_stat_t stat
);

  logic [IDX_W-1:0] mem [RING_DEPTH];

  logic [PTR_W-1:0] take_ptr;
  logic [PTR_W-1:0] ret_ptr;
  logic [PTR_W-1:0] take_ptr_next;
  logic [PTR_W-1:0] ret_ptr_next;
  logic [PTR_W-1:0] fill;
  logic             take_written;
  logic [IDX_W-1:0] rd_data;
  logic             rd_fresh;

  // Wrap at block_count: the ring has block_count + 1 slots.
  assign take_ptr_next = (take_ptr == PTR_W'(ctrl.block_count)) ? '0 : take_ptr + PTR_W'(1);
  assign ret_ptr_next  = (ret_ptr == PTR_W'(ctrl.block_count)) ? '0 : ret_ptr + PTR_W'(1);

  // Writes after init land on slot block_count first, then 0, 1, 2 and on;
  // a slot not reached yet reads as its own index.
  always_comb begin
    if (take_ptr == PTR_W'(ctrl.block_count)) begin
      take_written = (fill != '0);
    end else begin
      take_written = ({1'b0, fill} >= ({1'b0, take_ptr} + (PTR_W+1)'(2)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      take_ptr <= '0;
      ret_ptr  <= PTR_W'(MAX_BLOCKS);
      fill     <= '0;
    end else if (ctrl.init) begin
      take_ptr <= '0;
      ret_ptr  <= PTR_W'(ctrl.init_count);
      fill     <= '0;
    end else begin
      if (ctrl.take_adv) begin
        take_ptr <= take_ptr_next;
      end
      if (ctrl.ret_wr) begin
        ret_ptr <= ret_ptr_next;
        if (fill <= PTR_W'(ctrl.block_count)) begin
          fill <= fill + PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ret_wr) begin
      mem[ret_ptr] <= ctrl.wr_data;
    end
    rd_data  <= mem[take_ptr];
    rd_fresh <= ~take_written;
  end

  assign stat.empty  = (take_ptr == ret_ptr);
  assign stat.full   = (ret_ptr_next == take_ptr);
  assign stat.rd_blk = rd_fresh ? take_ptr[IDX_W-1:0] : rd_data;

endmodule

>>> sv/fixed_block_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_allocator
// Fixed-size block pool allocator with a ring of free block indices.
// ----------------------------------------------------------------------------
// The pool holds block_count blocks of block_units*16 bytes. An allocate
// request (operation 0) pops a free index and answers with its byte offset
// index*block_units*16 and the index; an empty pool answers status 1. A free
// request (operation 1) divides address by the block size, answers status 2
// when the index lies at or past block_count, status 3 when the free ring is
// full, and otherwise pushes the index back. Double frees are not detected.
// One request is worked on at a time and req.ready is low while it runs.
// An allocate reads the ring slot at acceptance, then multiplies the index
// by the block size and registers the result in the fetch state. An
// allocate on an empty pool, and a free whose offset lies far past any
// pool end, stage their result at acceptance. A free runs the serial
// divider, one quotient bit per cycle, hands the quotient over, and does
// the bounds check and ring update in the check state. Every path ends in
// the done state, which loads the output; the divider sets the free rate,
// and req.ready returns in the same cycle that the response becomes valid.
// The response sits in an output register, so a new request may be
// accepted while the last response waits; a stalled response holds the
// next result in place. Writing block_count (clamped to 1..256)
// reinitializes the ring; block_units changes only the block size (0 acts
// as 1). Registers lie at byte addresses 0 and 4 of the APB port; the user
// must write them only while idle, and the block does not enforce it. No
// clearing pass runs after reset: a fill count tracks which ring slots have
// been written since init, and the others read as their own index.
module fixed_block_allocator import fba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fba_req_if.sink           req,
  fba_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_DIV   = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [CNT_W-1:0]     block_count;
  logic [UNITS_W-1:0]   block_units;
  logic [UNITS_W-1:0]   units_eff;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic [CNT_W-1:0]     wr_value;
  logic [CNT_W-1:0]     count_clamp;

  // Staged result, then the output register.
  status_t          res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [IDX_W-1:0]  res_idx;
  logic              out_valid;
  status_t           out_status;
  logic [ADDR_W-1:0] out_addr;
  logic [IDX_W-1:0]  out_idx;

  logic              accept;
  logic              out_free;
  logic [DIVD_W-1:0] units_addr;
  logic              addr_too_big;
  logic [PROD_W-1:0] prod;

  ring_ctrl_t       ring_ctrl;
  ring_stat_t       ring_stat;
  div_req_t         div_req;
  logic             div_done;
  logic [QUO_W-1:0] quotient;

  // ---- APB register port --------------------------------------------------
  assign pready   = 1'b1;
  assign reg_idx  = paddr[APB_AW-1:2];
  assign cfg_wr   = psel && penable && pwrite;
  assign wr_value = pwdata[CNT_W-1:0];

  // Clamp block_count into 1..MAX_BLOCKS as it is written.
  always_comb begin
    if (wr_value == '0) begin
      count_clamp = CNT_W'(1);
    end else if (wr_value > CNT_W'(MAX_BLOCKS)) begin
      count_clamp = CNT_W'(MAX_BLOCKS);
    end else begin
      count_clamp = wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= CNT_W'(MAX_BLOCKS);
      block_units <= UNITS_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BLOCK_COUNT: block_count <= count_clamp;
        REG_BLOCK_UNITS: block_units <= pwdata[UNITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_COUNT: prdata = APB_DW'(block_count);
      REG_BLOCK_UNITS: prdata = APB_DW'(block_units);
      default:         prdata = '0;
    endcase
  end

  // Zero units behaves as one 16-byte unit.
  assign units_eff = (block_units == '0) ? UNITS_W'(1) : block_units;

  // ---- Request side -------------------------------------------------------
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Offset in 16-byte units; a high part at or above the divisor means the
  // quotient needs more than QUO_W bits, far past any pool end.
  assign units_addr   = req.address[ADDR_W-1:UNIT_SHIFT];
  assign addr_too_big = (units_addr[DIVD_W-1:QUO_W] >= HI_W'(units_eff));

  assign div_req.start    = accept && (req.operation == OP_FREE) && !addr_too_big;
  assign div_req.rem_init = units_addr[QUO_W +: UNITS_W];
  assign div_req.dividend = units_addr[QUO_W-1:0];
  assign div_req.divisor  = units_eff;

  fba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---- Free ring ----------------------------------------------------------
  assign ring_ctrl.init        = cfg_wr && (reg_idx == REG_BLOCK_COUNT);
  assign ring_ctrl.init_count  = count_clamp;
  assign ring_ctrl.block_count = block_count;
  assign ring_ctrl.take_adv    = (state == S_FETCH);
  assign ring_ctrl.ret_wr      = (state == S_CHECK) && (quotient < QUO_W'(block_count))
                                 && !ring_stat.full;
  assign ring_ctrl.wr_data     = quotient[IDX_W-1:0];

  fba_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ring_ctrl),
    .stat (ring_stat)
  );

  // ---- Sequencer ----------------------------------------------------------
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.operation == OP_ALLOC) begin
            state_next = ring_stat.empty ? S_DONE : S_FETCH;
          end else begin
            state_next = addr_too_big ? S_DONE : S_DIV;
          end
        end
      end
      S_FETCH: state_next = S_DONE;
      S_DIV: begin
        if (div_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Block offset of the popped index; registered before the output stage.
  assign prod = PROD_W'(ring_stat.rd_blk) * PROD_W'(units_eff);

  // Stage the result as each path finishes.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        res_status <= (req.operation == OP_ALLOC) ? ST_EMPTY : ST_BAD_ADDR;
        res_addr   <= '0;
        res_idx    <= '0;
      end
      S_FETCH: begin
        res_status <= ST_OK;
        res_addr   <= ADDR_W'({prod, UNIT_SHIFT'(0)});
        res_idx    <= ring_stat.rd_blk;
      end
      S_CHECK: begin
        res_addr <= '0;
        if (quotient >= QUO_W'(block_count)) begin
          res_status <= ST_BAD_ADDR;
          res_idx    <= '0;
        end else begin
          res_status <= ring_stat.full ? ST_FULL : ST_OK;
          res_idx    <= quotient[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---- Output register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_status <= res_status;
      out_addr   <= res_addr;
      out_idx    <= res_idx;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.block_address = out_addr;
  assign rsp.block_index   = out_idx;

endmodule

>>> sv/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks on the block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fba_checker import fba_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        rsp_status,
  input logic [ADDR_W-1:0] rsp_block_address,
  input logic [IDX_W-1:0]  rsp_block_index
);

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_status, rsp_block_address, rsp_block_index}), "response dropped or changed while stalled")

  `ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready, "request taken while one is in progress")

  `ASSERT_IMPL(a_fail_no_addr, clk, rst, rsp_valid && (rsp_status != ST_OK), rsp_block_address == '0, "failed request returned a block address")

  `ASSERT_IMPL(a_reject_no_idx, clk, rst, rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_BAD_ADDR), rsp_block_index == '0, "empty or bad address returned an index")

endmodule

bind fixed_block_allocator fba_checker u_fba_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_block_address (rsp.block_address),
  .rsp_block_index   (rsp.block_index)
);
